[rtl/core/touch_report_event_qualifier_top_macros.svh]
// ----------------------------------------------------------------------------
// Touch report event qualifier assertion macros
// Concurrent assertion shorthands clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_EVENT_QUALIFIER_TOP_MACROS_SVH
`define TOUCH_REPORT_EVENT_QUALIFIER_TOP_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define TRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger implies a consequent in the following cycle.
`define TRE_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[rtl/core/tre_pkg.sv]
// ----------------------------------------------------------------------------
// Touch report event qualifier package
// Shared types and constants for the qualifier core and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_pkg;

  // Position fields are panel pixels, 11 bits wide.
  localparam int POS_W = 11;
  // Divisor is a native maximum plus one: up to 65536.
  localparam int DIVISOR_W = 17;
  localparam int RAW_W = 16;
  localparam int DELAY_W = 10;

  localparam logic [DELAY_W-1:0] DELAY_MIN         = 10'd16;
  localparam logic [DELAY_W-1:0] DELAY_MAX         = 10'd100;
  localparam logic [DELAY_W-1:0] DELAY_STEP        = 10'd8;
  localparam logic [DELAY_W-1:0] DELAY_STATUS_FAIL = 10'd500;
  localparam logic [DELAY_W-1:0] DELAY_DATA_FAIL   = 10'd1000;

  localparam logic [1:0] RR_OK          = 2'd0;
  localparam logic [1:0] RR_STATUS_FAIL = 2'd1;
  localparam logic [1:0] RR_POINT_FAIL  = 2'd2;
  // spare code, handled like a point read failure
  localparam logic [1:0] RR_UNUSED      = 2'd3;

  localparam logic [1:0] REG_NATIVE_MAX_X   = 2'd0;
  localparam logic [1:0] REG_NATIVE_MAX_Y   = 2'd1;
  localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd2;

  localparam int ST_READY_BIT = 7;
  localparam int ST_LARGE_BIT = 6;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

[rtl/core/tre_div.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_div #(
  parameter int DIVIDEND_W = 27
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [DIVIDEND_W-1:0]            dividend,
  input  wire logic [tre_pkg::DIVISOR_W-1:0]    divisor,
  output logic      [DIVIDEND_W-1:0]            quotient,
  output tre_pkg::div_status_t                  status
);
  import tre_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    rem_shift = {rem, dvd[DIVIDEND_W-1]};
    fits      = rem_shift >= {1'b0, dsr};
    diff      = rem_shift - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= CNT_W'(DIVIDEND_W);
        busy <= 1'b1;
      end else if (busy) begin
        // quotient bits shift in where dividend bits shift out
        rem <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        dvd <= {dvd[DIVIDEND_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = dvd;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

[rtl/core/touch_report_event_qualifier_top.sv]
// ----------------------------------------------------------------------------
// Touch report event qualifier
// Scales and rotates the first touch point, qualifies down/move/up events
// and produces the adaptive poll interval.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | read_result .. point_size
//   out     | output    | out_valid / out_ready| event_kind .. next_poll_ms
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// A poll without point data passes S_CHECK and then S_OUT, where its result is registered.
// A touch poll runs both divisions through one divider, x first and then y,
// one quotient bit per cycle, before S_EVAL and S_OUT.
// One request is in flight; in_ready is low until its result is registered.
// The result register frees the input side while out_ready is held low.
// Synchronous reset clears touch state and out_valid, presets poll delay and config.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_report_event_qualifier_top #(
  parameter int PANEL_WIDTH  = 1200,
  parameter int PANEL_HEIGHT = 1920
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  read_result,
  input  wire logic [7:0]  status_byte,
  input  wire logic [15:0] raw_x,
  input  wire logic [15:0] raw_y,
  input  wire logic [3:0]  point_id,
  input  wire logic [15:0] point_size,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic [10:0]      out_x,
  output logic [10:0]      out_y,
  output logic [3:0]       out_id,
  output logic [15:0]      out_pressure,
  output logic [9:0]       next_poll_ms
);
  import tre_pkg::*;

  localparam int PANEL_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int PROD_W    = RAW_W + $clog2(PANEL_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVX,
    S_DIVY,
    S_EVAL,
    S_OUT
  } state_t;

  state_t state;

  logic [15:0] native_max_x;
  logic [15:0] native_max_y;
  logic [7:0]  move_threshold;

  logic             touching;
  logic [POS_W-1:0] last_pos_x;
  logic [POS_W-1:0] last_pos_y;
  logic [DELAY_W-1:0] poll_delay;

  logic [1:0]  rr_q;
  logic [7:0]  st_q;
  logic [15:0] rx_q;
  logic [15:0] ry_q;
  logic [3:0]  id_q;
  logic [15:0] sz_q;

  logic [POS_W-1:0] nx_q;
  logic [POS_W-1:0] ny_q;

  event_kind_t      res_kind;
  logic [POS_W-1:0] res_x;
  logic [POS_W-1:0] res_y;
  logic [3:0]       res_id;
  logic [15:0]      res_pr;

  logic                 div_start;
  logic [PROD_W-1:0]    div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [PROD_W-1:0]    div_quotient;
  div_status_t          div_stat;

  logic                 need_div;
  logic                 rel_hit;
  logic [PROD_W-1:0]    ny_full;
  logic [PROD_W-1:0]    nx_full;
  logic [DELAY_W:0]     delay_sum;
  logic [POS_W-1:0]     dx;
  logic [POS_W-1:0]     dy;
  logic                 moved;
  event_kind_t          rel_kind;
  logic [POS_W-1:0]     rel_x;
  logic [POS_W-1:0]     rel_y;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    need_div = (rr_q == RR_OK) && st_q[ST_READY_BIT] && (st_q[3:0] != 4'd0)
               && !st_q[ST_LARGE_BIT];
    // an empty point list or a large contact releases the touch
    rel_hit  = (rr_q != RR_STATUS_FAIL) && st_q[ST_READY_BIT]
               && ((st_q[3:0] == 4'd0) || ((rr_q == RR_OK) && st_q[ST_LARGE_BIT]));
    div_start = ((state == S_CHECK) && need_div) || ((state == S_DIVX) && div_stat.done);

    // x goes first, y follows as soon as x finishes
    if (state == S_DIVX) begin
      div_dividend = PROD_W'(ry_q) * PROD_W'(PANEL_HEIGHT);
      div_divisor  = {1'b0, native_max_y} + DIVISOR_W'(1);
    end else begin
      div_dividend = PROD_W'(rx_q) * PROD_W'(PANEL_WIDTH);
      div_divisor  = {1'b0, native_max_x} + DIVISOR_W'(1);
    end

    // scaled x becomes logical y, clamped to the panel width
    ny_full = (div_quotient >= PROD_W'(PANEL_WIDTH)) ? PROD_W'(PANEL_WIDTH - 1) : div_quotient;
    // scaled y mirrors into logical x, floored at zero
    nx_full = (div_quotient >= PROD_W'(PANEL_HEIGHT)) ? '0
              : PROD_W'(PANEL_HEIGHT - 1) - div_quotient;

    delay_sum = {1'b0, poll_delay} + {1'b0, DELAY_STEP};

    dx = (nx_q > last_pos_x) ? nx_q - last_pos_x : last_pos_x - nx_q;
    dy = (ny_q > last_pos_y) ? ny_q - last_pos_y : last_pos_y - ny_q;
    moved = (dx > POS_W'(move_threshold)) || (dy > POS_W'(move_threshold));

    rel_kind = touching ? EV_UP : EV_NONE;
    rel_x    = touching ? last_pos_x : '0;
    rel_y    = touching ? last_pos_y : '0;
  end

  tre_div #(
    .DIVIDEND_W (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      native_max_x   <= 16'd4095;
      native_max_y   <= 16'd4095;
      move_threshold <= 8'd4;
      touching       <= 1'b0;
      last_pos_x     <= '0;
      last_pos_y     <= '0;
      poll_delay     <= DELAY_MIN;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NATIVE_MAX_X:   native_max_x   <= cfg_data;
          REG_NATIVE_MAX_Y:   native_max_y   <= cfg_data;
          REG_MOVE_THRESHOLD: move_threshold <= cfg_data[7:0];
          default: ;
        endcase
      end

      // a result loaded in S_OUT keeps the register full
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rr_q  <= read_result;
            st_q  <= status_byte;
            rx_q  <= raw_x;
            ry_q  <= raw_y;
            id_q  <= point_id;
            sz_q  <= point_size;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_kind <= rel_hit ? rel_kind : EV_NONE;
          res_x    <= rel_hit ? rel_x : '0;
          res_y    <= rel_hit ? rel_y : '0;
          res_id   <= '0;
          res_pr   <= '0;
          state    <= need_div ? S_DIVX : S_OUT;
          if (rr_q == RR_STATUS_FAIL) begin
            poll_delay <= DELAY_STATUS_FAIL;
          end else if (!st_q[ST_READY_BIT]) begin
            // back off while the controller has nothing ready
            poll_delay <= (delay_sum > {1'b0, DELAY_MAX}) ? DELAY_MAX
                          : delay_sum[DELAY_W-1:0];
          end else if (st_q[3:0] == 4'd0) begin
            poll_delay <= DELAY_MIN;
            touching   <= 1'b0;
            last_pos_x <= '0;
            last_pos_y <= '0;
          end else if (rr_q != RR_OK) begin
            poll_delay <= DELAY_DATA_FAIL;
          end else if (st_q[ST_LARGE_BIT]) begin
            // large contact counts as a release
            poll_delay <= DELAY_MIN;
            touching   <= 1'b0;
            last_pos_x <= '0;
            last_pos_y <= '0;
          end else begin
            poll_delay <= DELAY_MIN;
          end
        end
        S_DIVX: begin
          if (div_stat.done) begin
            ny_q  <= ny_full[POS_W-1:0];
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_stat.done) begin
            nx_q  <= nx_full[POS_W-1:0];
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_kind   <= (touching && moved) ? EV_MOVE : EV_DOWN;
          res_x      <= nx_q;
          res_y      <= ny_q;
          res_id     <= id_q;
          res_pr     <= sz_q;
          touching   <= 1'b1;
          last_pos_x <= nx_q;
          last_pos_y <= ny_q;
          state      <= S_OUT;
        end
        S_OUT: begin
          // hold until the result register is free
          if (!out_valid || out_ready) begin
            event_kind   <= res_kind;
            out_x        <= res_x;
            out_y        <= res_y;
            out_id       <= res_id;
            out_pressure <= res_pr;
            next_poll_ms <= poll_delay;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "touch_report_event_qualifier_top_macros.svh"

  `TRE_ASSERT(a_div_start_idle, !(div_start && div_stat.busy), "divider restarted while busy")
  `TRE_ASSERT(a_div_done_state,
              !div_stat.done || state == S_DIVX || state == S_DIVY,
              "divider done outside a divide step")
  `TRE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "request taken while a request is in flight")
  `TRE_ASSERT(a_delay_range,
              !out_valid || (next_poll_ms >= DELAY_MIN && next_poll_ms <= DELAY_DATA_FAIL),
              "poll delay out of range")

endmodule

`default_nettype wire
